FILE: rtl/core/srba_pkg.sv
package srba_pkg;

    // Item kinds carried on i_kind.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam int unsigned SCAN_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned YSUM_W  = 64;
    localparam int unsigned Y2SUM_W = 63;
    localparam int unsigned TIME_W  = 63;
    localparam int unsigned PORT_IDX_W = 7;

    // Register reset value of the active bin count.
    localparam logic [7:0] ACTIVE_BINS_RESET = 8'd100;

    // One bin as it is held in the store.
    typedef struct packed {
        logic signed [SCAN_W-1:0]  scan_value;
        logic        [COUNT_W-1:0] count;
        logic signed [YSUM_W-1:0]  y_sum;
        logic        [Y2SUM_W-1:0] y2_sum;
        logic        [TIME_W-1:0]  time_stamp;
    } t_bin;

endpackage

FILE: rtl/core/scan_ring_bin_accumulator.sv
// Scan-bin ring accumulator. Each accepted item (start high while busy is low)
// produces exactly one result, shown for a single cycle with o_result_valid
// high, once the item has passed the S_MUL and S_UPD states; the receiver
// cannot hold results off, so it must take every strobe. An item passes
// through the read of the bin store (a single-port synchronous memory with a
// registered read), the second multiplication stage of y*y*weight, and the
// saturating update and write-back. busy is high in the last two of these,
// so the next item can be taken in the cycle in which the previous result
// is shown, and not before. After reset the store is cleared by a sweep
// over all MAX_BINS bins, one bin per cycle, during which busy stays high.
// The active bin count register may be written at any time through the
// configuration channel (o_cfg_ready is always high), though it should
// only change while no item is in progress.
module scan_ring_bin_accumulator
    import srba_pkg::*;
#(
    parameter int unsigned MAX_BINS = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       start,
    output logic                       busy,
    input  logic                       i_kind,
    input  logic signed [15:0]         i_sample_y,
    input  logic signed [SCAN_W-1:0]   i_scan_value,
    input  logic        [15:0]         i_weight,
    input  logic        [TIME_W-1:0]   i_timestamp,
    input  logic        [PORT_IDX_W-1:0] i_read_index,

    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic        [7:0]          i_cfg_data,

    output logic                       o_result_valid,
    output logic        [PORT_IDX_W-1:0] o_bin_index,
    output logic signed [SCAN_W-1:0]   o_bin_scan_value,
    output logic        [COUNT_W-1:0]  o_bin_count,
    output logic signed [YSUM_W-1:0]   o_bin_y_sum,
    output logic        [Y2SUM_W-1:0]  o_bin_y2_sum,
    output logic        [TIME_W-1:0]   o_bin_time,
    output logic        [PORT_IDX_W-1:0] o_newest_bin
);

    localparam int unsigned IDX_W = $clog2(MAX_BINS);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    // Control state.
    logic [1:0]       r_state;
    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_addr;
    logic [IDX_W-1:0] r_ptr;
    logic [7:0]       r_active_bins;

    // Item held while it is being worked on.
    logic                     r_kind;
    logic signed [SCAN_W-1:0] r_x;
    logic [15:0]              r_w;
    logic [TIME_W-1:0]        r_t;
    logic [PORT_IDX_W-1:0]    r_ridx;
    logic                     r_rd_ok;
    logic signed [32:0]       r_yw;
    logic [30:0]              r_ysq;
    logic [46:0]              r_y2w;

    // Bin store and its registered read data.
    t_bin r_bin_mem [MAX_BINS];
    t_bin r_rdata;

    logic             w_accept;
    logic [31:0]      w_ridx_ext;
    logic [IDX_W-1:0] w_raddr;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_bin             w_wdata;

    logic             w_match;
    logic [31:0]      w_eff;
    logic [31:0]      w_ptr_next;
    logic [IDX_W-1:0] w_bin;
    logic [32:0]      w_cnt_sum;
    logic [64:0]      w_ys_sum;
    logic [63:0]      w_y2_sum;
    t_bin             w_upd;
    logic [31:0]      w_bin_ext;

    assign busy        = (r_state != S_IDLE) || r_clearing;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // Read address: the bin asked for by a read item, else the ring pointer.
    assign w_ridx_ext = 32'(i_read_index);
    assign w_raddr    = (i_kind == KIND_READ) ? w_ridx_ext[IDX_W-1:0] : r_ptr;

    always_comb begin
        w_match   = (r_x == r_rdata.scan_value);
        w_eff     = (r_active_bins == 8'd0) ? 32'd1 :
                    ((32'(r_active_bins) > MAX_BINS) ? 32'(MAX_BINS) : 32'(r_active_bins));
        w_ptr_next = 32'(r_ptr) + 32'd1;
        if (w_match || (r_rdata.count == '0)) begin
            w_bin = r_ptr;
        end else if (w_ptr_next >= w_eff) begin
            w_bin = '0;
        end else begin
            w_bin = w_ptr_next[IDX_W-1:0];
        end

        w_cnt_sum = {1'b0, r_rdata.count} + 33'(r_w);
        w_ys_sum  = {r_rdata.y_sum[63], r_rdata.y_sum} + {{32{r_yw[32]}}, r_yw};
        w_y2_sum  = {1'b0, r_rdata.y2_sum} + 64'(r_y2w);

        if (w_match) begin
            w_upd.scan_value = r_rdata.scan_value;
            w_upd.count      = w_cnt_sum[32] ? '1 : w_cnt_sum[31:0];
            if (w_ys_sum[64] != w_ys_sum[63]) begin
                // Overflow: clamp towards the sign of the true sum.
                w_upd.y_sum = w_ys_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
                w_upd.y_sum = w_ys_sum[63:0];
            end
            w_upd.y2_sum     = w_y2_sum[63] ? '1 : w_y2_sum[62:0];
            w_upd.time_stamp = r_rdata.time_stamp;
        end else begin
            w_upd.scan_value = r_x;
            w_upd.count      = 32'(r_w);
            w_upd.y_sum      = {{31{r_yw[32]}}, r_yw};
            w_upd.y2_sum     = 63'(r_y2w);
            w_upd.time_stamp = r_t;
        end

        w_bin_ext = 32'(w_bin);

        // The clearing sweep and the sample write-back never overlap.
        w_we    = r_clearing || ((r_state == S_UPD) && (r_kind == KIND_SAMPLE));
        w_waddr = r_clearing ? r_clr_addr : w_bin;
        w_wdata = r_clearing ? '0 : w_upd;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_bin_mem[w_waddr] <= w_wdata;
        end
        if (w_accept) begin
            r_rdata <= r_bin_mem[w_raddr];
        end
    end

    // Item capture and the multiplier stages.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_x     <= i_scan_value;
            r_w     <= i_weight;
            r_t     <= i_timestamp;
            r_ridx  <= i_read_index;
            r_rd_ok <= (w_ridx_ext < MAX_BINS);
            r_yw    <= $signed({{17{i_sample_y[15]}}, i_sample_y}) *
                       $signed({17'd0, i_weight});
            r_ysq   <= $signed({{15{i_sample_y[15]}}, i_sample_y}) *
                       $signed({{15{i_sample_y[15]}}, i_sample_y});
        end
        if (r_state == S_MUL) begin
            r_y2w <= {16'd0, r_ysq} * {31'd0, r_w};
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            if (r_kind == KIND_READ) begin
                o_bin_index  <= r_ridx;
                o_newest_bin <= PORT_IDX_W'(r_ptr);
                if (r_rd_ok) begin
                    o_bin_scan_value <= r_rdata.scan_value;
                    o_bin_count      <= r_rdata.count;
                    o_bin_y_sum      <= r_rdata.y_sum;
                    o_bin_y2_sum     <= r_rdata.y2_sum;
                    o_bin_time       <= r_rdata.time_stamp;
                end else begin
                    o_bin_scan_value <= '0;
                    o_bin_count      <= '0;
                    o_bin_y_sum      <= '0;
                    o_bin_y2_sum     <= '0;
                    o_bin_time       <= '0;
                end
            end else begin
                o_bin_index      <= w_bin_ext[PORT_IDX_W-1:0];
                o_newest_bin     <= w_bin_ext[PORT_IDX_W-1:0];
                o_bin_scan_value <= w_upd.scan_value;
                o_bin_count      <= w_upd.count;
                o_bin_y_sum      <= w_upd.y_sum;
                o_bin_y2_sum     <= w_upd.y2_sum;
                o_bin_time       <= w_upd.time_stamp;
            end
        end
    end

    // Control: sequencer, ring pointer, clearing sweep and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_clearing     <= 1'b1;
            r_clr_addr     <= '0;
            r_ptr          <= '0;
            r_active_bins  <= ACTIVE_BINS_RESET;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= (r_state == S_UPD);
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
                if (32'(r_clr_addr) == MAX_BINS - 1) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_active_bins <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_kind == KIND_SAMPLE) begin
                        r_ptr <= w_bin;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Every accepted item yields its result once it has passed the S_MUL and S_UPD states.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##3 o_result_valid)
        else $error("accepted item produced no result after three cycles");

    // A result strobe is only ever the product of an update step.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(i_rst_n)) |-> ($past(r_state) == S_UPD))
        else $error("result strobe without an update step");

    // The ring pointer only moves when a sample is written back.
    a_ptr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && ($past(r_state) != S_UPD)) |-> $stable(r_ptr))
        else $error("ring pointer moved outside an update step");

    // No item is taken while the store is being cleared.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !w_accept && (r_state == S_IDLE))
        else $error("item accepted during the clearing sweep");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the scan-bin ring accumulator.
//
// A queue of pending entries is filled once at time zero. Each entry is either
// a sample item, a read item or a new setting for the active bin count. A
// clocked driver works through the queue at the falling edge, and a clocked
// monitor samples the block at the rising edge. At each accepted item the
// monitor runs the bench's own model of the bin store and keeps the bin
// contents the block should report. Each result strobe is then compared
// field by field with the oldest of those.
//
// The stimulus starts with a short hand-written sequence covering the field
// extremes and the awkward corners of the ring:
// - matching a bin that has never been filled;
// - opening a bin with zero weight;
// - reads at both ends of the store.
// After that come random phases under a range of active bin counts: zero,
// one, the largest value, which is above the store size, and a shrink that
// can leave the pointer beyond the new count. A final run of full-scale
// samples, alike but for their timestamps, piles large sums onto one bin.
module tb;
    import srba_pkg::*;

    localparam int unsigned BINS = 128;
    // Full-scale samples with one scan value, sent back to back onto one bin.
    localparam int unsigned HEAVY_RUN = 16;
    localparam logic signed [SCAN_W-1:0] HEAVY_KEY = 32'sh5A5A_0001;
    // The limit lies well above the slowest correct run: the clearing sweep
    // and about 670 items, each with its idle gap and busy time, and a short
    // wait before each setting.
    localparam int unsigned LIMIT_CYCLES = 50_000;
    // A short wait after the last expected result is enough to catch any
    // stray strobe.
    localparam int unsigned DRAIN_CYCLES = 8;

    // One queued entry: an item for the command port, or a setting for the
    // configuration channel. gap is the number of idle cycles before it.
    typedef struct {
        bit                       is_setting;
        logic [7:0]               setting;
        logic                     kind;
        logic signed [15:0]       y;
        logic signed [SCAN_W-1:0] x;
        logic [15:0]              w;
        logic [TIME_W-1:0]        ts;
        logic [PORT_IDX_W-1:0]    ridx;
        int unsigned              gap;
    } t_feed;

    // The bin contents that the block should report for one item.
    typedef struct {
        logic [PORT_IDX_W-1:0]    idx;
        logic signed [SCAN_W-1:0] x;
        logic [COUNT_W-1:0]       cnt;
        logic signed [YSUM_W-1:0] ys;
        logic [Y2SUM_W-1:0]       y2s;
        logic [TIME_W-1:0]        tm;
        logic [PORT_IDX_W-1:0]    newest;
    } t_bin_result;

    // Block ports. Every input is given a known value from time zero.
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       i_kind = KIND_SAMPLE;
    logic signed [15:0]         i_sample_y = '0;
    logic signed [SCAN_W-1:0]   i_scan_value = '0;
    logic [15:0]                i_weight = '0;
    logic [TIME_W-1:0]          i_timestamp = '0;
    logic [PORT_IDX_W-1:0]      i_read_index = '0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [7:0]                 i_cfg_data = '0;
    logic                       o_result_valid;
    logic [PORT_IDX_W-1:0]      o_bin_index;
    logic signed [SCAN_W-1:0]   o_bin_scan_value;
    logic [COUNT_W-1:0]         o_bin_count;
    logic signed [YSUM_W-1:0]   o_bin_y_sum;
    logic [Y2SUM_W-1:0]         o_bin_y2_sum;
    logic [TIME_W-1:0]          o_bin_time;
    logic [PORT_IDX_W-1:0]      o_newest_bin;

    // The bench's own copy of the bin store, ring pointer and register.
    logic signed [SCAN_W-1:0]   held_x   [BINS] = '{default: '0};
    logic [COUNT_W-1:0]         held_cnt [BINS] = '{default: '0};
    logic signed [YSUM_W-1:0]   held_ys  [BINS] = '{default: '0};
    logic [Y2SUM_W-1:0]         held_y2  [BINS] = '{default: '0};
    logic [TIME_W-1:0]          held_t   [BINS] = '{default: '0};
    logic [PORT_IDX_W-1:0]      ring_ptr = '0;
    logic [7:0]                 active_bins_set = ACTIVE_BINS_RESET;

    t_feed        pending[$];
    t_bin_result  bin_results_due[$];

    // Handshake flags, set at the rising edge and read by the driver at the
    // following falling edge.
    bit           item_taken = 1'b0;
    bit           setting_taken = 1'b0;
    bit           go_item;
    bit           go_setting;

    int unsigned  cycle_cnt = 0;
    int unsigned  total_items = 0;
    int unsigned  items_accepted = 0;
    int unsigned  samples_accepted = 0;
    int unsigned  reads_accepted = 0;
    int unsigned  settings_accepted = 0;
    int unsigned  results_checked = 0;
    int unsigned  errors = 0;
    logic signed [SCAN_W-1:0] last_scan = '0;

    scan_ring_bin_accumulator #(
        .MAX_BINS (BINS)
    ) u_top (
        .i_clk,
        .i_rst_n,
        .start,
        .busy,
        .i_kind,
        .i_sample_y,
        .i_scan_value,
        .i_weight,
        .i_timestamp,
        .i_read_index,
        .i_cfg_valid,
        .o_cfg_ready,
        .i_cfg_data,
        .o_result_valid,
        .o_bin_index,
        .o_bin_scan_value,
        .o_bin_count,
        .o_bin_y_sum,
        .o_bin_y2_sum,
        .o_bin_time,
        .o_newest_bin
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        errors++;
        $display("MISMATCH cycle %0d, %s: got %h, expected %h",
                 cycle_cnt, what, got, want);
    endtask

    // Works out what the block should report for one accepted item and
    // applies the item to the bench's copy of the store.
    task automatic accumulate_bin(input t_feed it, output t_bin_result r);
        logic signed [63:0] yw;
        logic signed [63:0] y2w;
        logic [32:0]        cnt_sum;
        logic signed [64:0] y_sum;
        logic [63:0]        y2_sum;
        int unsigned        bin;
        int unsigned        span;
        // A count of zero behaves as one bin, and anything above the store
        // size as the whole store.
        if (active_bins_set == 0) begin
            span = 1;
        end else if (active_bins_set > BINS) begin
            span = BINS;
        end else begin
            span = active_bins_set;
        end
        r = '{default: '0};
        if (it.kind == KIND_READ) begin
            // A read beyond the store reports the index it was given with
            // empty contents; a read changes nothing.
            r.idx = it.ridx;
            if (it.ridx < BINS) begin
                r.x   = held_x[it.ridx];
                r.cnt = held_cnt[it.ridx];
                r.ys  = held_ys[it.ridx];
                r.y2s = held_y2[it.ridx];
                r.tm  = held_t[it.ridx];
            end
        end else begin
            yw  = it.y * $signed({1'b0, it.w});
            y2w = yw * it.y;
            bin = ring_ptr;
            if (bin >= BINS) begin
                bin = 0;
            end
            if (it.x == held_x[bin]) begin
                // Same scan step: add to the bin and leave its time alone.
                // This also holds for a bin that has never been filled.
                cnt_sum = held_cnt[bin] + it.w;
                held_cnt[bin] = cnt_sum[32] ? '1 : cnt_sum[31:0];
                y_sum = held_ys[bin] + yw;
                if (y_sum[64] != y_sum[63]) begin
                    held_ys[bin] = y_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end else begin
                    held_ys[bin] = y_sum[63:0];
                end
                y2_sum = held_y2[bin] + y2w[62:0];
                held_y2[bin] = y2_sum[63] ? '1 : y2_sum[62:0];
            end else begin
                // New scan step. An empty bin (zero count, e.g. opened with
                // zero weight) is reused; otherwise the pointer moves on and
                // wraps at the active count, even from beyond it.
                if (held_cnt[bin] != 0) begin
                    bin++;
                    if (bin >= span) begin
                        bin = 0;
                    end
                end
                held_x[bin]   = it.x;
                held_cnt[bin] = it.w;
                held_ys[bin]  = yw;
                held_y2[bin]  = y2w[62:0];
                held_t[bin]   = it.ts;
                ring_ptr      = PORT_IDX_W'(bin);
            end
            r.idx = PORT_IDX_W'(bin);
            r.x   = held_x[bin];
            r.cnt = held_cnt[bin];
            r.ys  = held_ys[bin];
            r.y2s = held_y2[bin];
            r.tm  = held_t[bin];
        end
        r.newest = ring_ptr;
    endtask

    task automatic queue_sample(input logic signed [SCAN_W-1:0] x,
                                input logic signed [15:0] y, input logic [15:0] w,
                                input logic [TIME_W-1:0] ts, input int unsigned gap);
        t_feed e;
        e = '{default: '0};
        e.kind = KIND_SAMPLE;
        e.x    = x;
        e.y    = y;
        e.w    = w;
        e.ts   = ts;
        e.ridx = PORT_IDX_W'($urandom);
        e.gap  = gap;
        pending.push_back(e);
        total_items++;
    endtask

    // The unused fields of a read item carry random values, so that the
    // block is seen to ignore them.
    task automatic queue_read(input logic [PORT_IDX_W-1:0] idx, input int unsigned gap);
        t_feed e;
        e = '{default: '0};
        e.kind = KIND_READ;
        e.x    = $urandom;
        e.y    = 16'($urandom);
        e.w    = 16'($urandom);
        e.ts   = TIME_W'({$urandom, $urandom});
        e.ridx = idx;
        e.gap  = gap;
        pending.push_back(e);
        total_items++;
    endtask

    task automatic queue_setting(input logic [7:0] value);
        t_feed e;
        e = '{default: '0};
        e.is_setting = 1'b1;
        e.setting    = value;
        e.gap        = $urandom_range(0, 7);
        pending.push_back(e);
    endtask

    // A random phase. About three in eight of the samples repeat the previous
    // scan value so that bins really accumulate. The rest either draw from a
    // small pool of values, which forces frequent bin changes and ring
    // wraps, or take a fully random value. Reads mostly land inside the
    // active part of the ring. Idle gaps are random, with runs of
    // back-to-back items.
    task automatic queue_random_phase(input int unsigned n, input int unsigned span);
        logic signed [SCAN_W-1:0] x;
        logic [15:0]              w;
        logic [PORT_IDX_W-1:0]    idx;
        int unsigned              sel;
        int unsigned              gap;
        bit                       burst;
        x = last_scan;
        burst = 1'b0;
        for (int unsigned i = 0; i < n; i++) begin
            gap = burst ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 15) == 0) begin
                burst = !burst;
            end
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                idx = PORT_IDX_W'(($urandom_range(0, 3) == 0) ?
                                  $urandom_range(0, BINS - 1) :
                                  $urandom_range(0, span - 1));
                queue_read(idx, gap);
            end else begin
                if (sel >= 80) begin
                    x = $urandom;
                end else if (sel >= 50) begin
                    x = $urandom_range(0, 5) - 2;
                end
                case ($urandom_range(0, 9))
                    0: w = '0;
                    1: w = '1;
                    default: w = 16'($urandom);
                endcase
                queue_sample(x, 16'($urandom), w, TIME_W'({$urandom, $urandom}), gap);
            end
        end
        last_scan = x;
    endtask

    // Driver. An entry stays on the ports until its handshake completes and
    // is then taken off the queue. A setting is only offered once every
    // outstanding result has come back, so the block is idle when it lands.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (item_taken || setting_taken) begin
                void'(pending.pop_front());
            end
            if (!(start && !item_taken) && !(i_cfg_valid && !setting_taken)) begin
                go_item = 1'b0;
                go_setting = 1'b0;
                if (pending.size() != 0) begin
                    if (pending[0].gap != 0) begin
                        pending[0].gap--;
                    end else if (pending[0].is_setting) begin
                        if (bin_results_due.size() == 0) begin
                            go_setting = 1'b1;
                            i_cfg_data <= pending[0].setting;
                        end
                    end else begin
                        go_item = 1'b1;
                        i_kind       <= pending[0].kind;
                        i_sample_y   <= pending[0].y;
                        i_scan_value <= pending[0].x;
                        i_weight     <= pending[0].w;
                        i_timestamp  <= pending[0].ts;
                        i_read_index <= pending[0].ridx;
                    end
                end
                start <= go_item;
                i_cfg_valid <= go_setting;
            end
        end
    end

    // Monitor. Results are checked before the model takes a new item, which
    // keeps the oldest expectation at the front of the queue.
    always @(posedge i_clk) begin
        t_bin_result want;
        t_bin_result fresh;
        t_feed       seen;
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d of %0d items accepted.",
                     cycle_cnt, items_accepted, total_items);
            $display("DONE: errors detected");
            $finish;
        end else begin
            item_taken = i_rst_n && start && !busy;
            setting_taken = i_rst_n && i_cfg_valid && o_cfg_ready;
            if (i_rst_n && o_result_valid !== 1'b0) begin
                if (bin_results_due.size() == 0) begin
                    flag_mismatch("result with nothing pending", o_bin_index, '0);
                end else begin
                    want = bin_results_due.pop_front();
                    results_checked++;
                    if (o_bin_index !== want.idx)
                        flag_mismatch("bin_index", o_bin_index, want.idx);
                    if (o_bin_scan_value !== want.x)
                        flag_mismatch("bin_scan_value", o_bin_scan_value, want.x);
                    if (o_bin_count !== want.cnt)
                        flag_mismatch("bin_count", o_bin_count, want.cnt);
                    if (o_bin_y_sum !== want.ys)
                        flag_mismatch("bin_y_sum", o_bin_y_sum, want.ys);
                    if (o_bin_y2_sum !== want.y2s)
                        flag_mismatch("bin_y2_sum", o_bin_y2_sum, want.y2s);
                    if (o_bin_time !== want.tm)
                        flag_mismatch("bin_time", o_bin_time, want.tm);
                    if (o_newest_bin !== want.newest)
                        flag_mismatch("newest_bin", o_newest_bin, want.newest);
                end
            end
            if (setting_taken) begin
                active_bins_set = i_cfg_data;
                settings_accepted++;
            end
            if (item_taken) begin
                seen = '{default: '0};
                seen.kind = i_kind;
                seen.x    = i_scan_value;
                seen.y    = i_sample_y;
                seen.w    = i_weight;
                seen.ts   = i_timestamp;
                seen.ridx = i_read_index;
                accumulate_bin(seen, fresh);
                bin_results_due.push_back(fresh);
                items_accepted++;
                if (i_kind == KIND_READ) begin
                    reads_accepted++;
                end else begin
                    samples_accepted++;
                end
            end
        end
    end

    initial begin
        // Hand-written opening under the reset value of the active count.
        // Before any bin is filled every bin holds scan value 0, so a sample
        // at 0 adds to bin 0 and its time stays at zero.
        queue_read(0, $urandom_range(0, 7));
        queue_read(PORT_IDX_W'(BINS - 1), $urandom_range(0, 7));
        queue_sample(0, 16'sd5, 16'd3, 63'd123, $urandom_range(0, 7));
        queue_sample(0, 16'sh8000, 16'hFFFF, {63{1'b1}}, $urandom_range(0, 7));
        // Zero weight opens a bin that the next new value reuses.
        queue_sample(7, 16'sh7FFF, 16'd0, {63{1'b1}}, $urandom_range(0, 7));
        queue_sample(8, -16'sd1, 16'd10, 63'd1, $urandom_range(0, 7));
        queue_sample(8, 16'sd0, 16'd0, 63'd5, $urandom_range(0, 7));
        queue_sample(32'sh8000_0000, 16'sh7FFF, 16'hFFFF, '0, $urandom_range(0, 7));
        queue_sample(32'sh7FFF_FFFF, 16'sh8000, 16'd1, {63{1'b1}}, $urandom_range(0, 7));
        queue_sample(32'sh7FFF_FFFF, 16'sh8000, 16'hFFFF, '0, $urandom_range(0, 7));
        queue_sample(-32'sd1, 16'sd1, 16'hFFFF, TIME_W'({$urandom, $urandom}),
                     $urandom_range(0, 7));
        queue_sample(0, 16'sh8000, 16'd0, '0, $urandom_range(0, 7));
        queue_sample(1, 16'sd1, 16'd1, {63{1'b1}}, $urandom_range(0, 7));
        for (int unsigned i = 0; i < 7; i++) begin
            queue_read(PORT_IDX_W'(i), $urandom_range(0, 7));
        end
        queue_read(PORT_IDX_W'(ACTIVE_BINS_RESET - 1), $urandom_range(0, 7));
        last_scan = 1;
        queue_random_phase(80, ACTIVE_BINS_RESET);

        // A sweep of active counts: small, zero (acts as one), above the
        // store size, one, two, exactly the store size, a random middle
        // value, and finally a shrink that can leave the pointer beyond the
        // count so that the next advance wraps to zero.
        queue_setting(8'd3);
        queue_random_phase(80, 3);
        queue_setting(8'd0);
        queue_random_phase(60, 1);
        queue_setting(8'd255);
        queue_random_phase(80, BINS);
        queue_setting(8'd1);
        queue_random_phase(50, 1);
        queue_setting(8'd2);
        queue_random_phase(60, 2);
        queue_setting(8'(BINS));
        queue_random_phase(60, BINS);
        begin
            int unsigned mid;
            mid = $urandom_range(4, BINS - 1);
            queue_setting(8'(mid));
            queue_random_phase(80, mid);
        end
        queue_setting(8'd5);
        queue_random_phase(70, 5);

        // Full-scale samples back to back on a single bin, then a look at
        // every active bin.
        queue_setting(8'd4);
        for (int unsigned i = 0; i < HEAVY_RUN; i++) begin
            queue_sample(HEAVY_KEY, 16'sh8000, 16'hFFFF, TIME_W'({$urandom, $urandom}), 0);
        end
        for (int unsigned i = 0; i < 4; i++) begin
            queue_read(PORT_IDX_W'(i), $urandom_range(0, 7));
        end
        queue_sample(HEAVY_KEY, 16'sh7FFF, 16'hFFFF, '0, 0);
        queue_sample(~HEAVY_KEY, 16'sh7FFF, 16'hFFFF, '0, $urandom_range(0, 7));

        // Synchronous reset, released on a falling edge. The block then clears
        // its store with busy high, which the driver simply waits out.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (!(items_accepted == total_items && bin_results_due.size() == 0));
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (bin_results_due.size() != 0) begin
            flag_mismatch("results never delivered", bin_results_due.size(), '0);
        end

        $display("Covered %0d samples and %0d reads under %0d active-bin settings.",
                 samples_accepted, reads_accepted, settings_accepted);
        $display("Checked %0d results, including a run of %0d full-scale samples on one bin.",
                 results_checked, HEAVY_RUN);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
